>>> src/mul_div_cycle_timing_defines.svh
// ----------------------------------------------------------------------------
// mul_div_cycle_timing_defines
// assertion macros shared by the cycle timing block; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef MUL_DIV_CYCLE_TIMING_DEFINES_SVH
`define MUL_DIV_CYCLE_TIMING_DEFINES_SVH

`ifndef SYNTHESIS
// concurrent check, masked while reset is asserted
`define MDCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// concurrent check that also holds while reset is asserted
`define MDCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MDCT_ASSERT(lbl, prop, msg)
`define MDCT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> src/mdct_pkg.sv
// ----------------------------------------------------------------------------
// mdct_pkg
// types, constants and helpers of the multiply / divide cycle timing block
// ----------------------------------------------------------------------------
package mdct_pkg;

  // instruction codes
  typedef enum logic [1:0] {
    FUNC_MULU = 2'd0,
    FUNC_MULS = 2'd1,
    FUNC_DIVU = 2'd2,
    FUNC_DIVS = 2'd3
  } func_e;

  // divide steps per pipeline stage and number of divide stages
  localparam int unsigned STAGE_STEPS = 5;
  localparam int unsigned DIV_STAGES  = 3;

  // base counts
  localparam logic [7:0] MUL_BASE      = 8'd38;
  localparam logic [6:0] DIVU_HALF     = 7'd38;
  localparam logic [7:0] DIVU_OVF_BASE = 8'd10;
  localparam logic [6:0] DIVS_HALF     = 7'd61;
  localparam logic [7:0] DIVS_OVF_BASE = 8'd16;

  // item after operand preparation
  typedef struct packed {
    func_e       func;
    logic [3:0]  cost;
    logic        zero;
    logic        nneg;
    logic        dneg;
    logic [31:0] dvd;
    logic [15:0] div;
    logic [4:0]  acc;
  } prep_t;

  // item travelling through the divide step stages
  typedef struct packed {
    func_e       func;
    logic [3:0]  cost;
    logic        zero;
    logic        nneg;
    logic        dneg;
    logic        ovf;
    logic [15:0] div;
    logic [15:0] rem;
    logic [15:0] lo;
    logic [4:0]  acc;
  } div_pipe_t;

  // word-size effective address cost
  function automatic logic [3:0] addr_cost(logic [2:0] mode, logic [2:0] ea_reg);
    logic [3:0] c;
    case (mode)
      3'd0, 3'd1: c = 4'd0;
      3'd2, 3'd3: c = 4'd4;
      3'd4:       c = 4'd6;
      3'd5:       c = 4'd8;
      3'd6:       c = 4'd10;
      default: begin
        case (ea_reg)
          3'd1:    c = 4'd12;
          3'd3:    c = 4'd10;
          3'd4:    c = 4'd4;
          default: c = 4'd8;
        endcase
      end
    endcase
    return c;
  endfunction

  // number of set bits in a halfword
  function automatic logic [4:0] pop16(logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> src/mdct_if.sv
// ----------------------------------------------------------------------------
// mdct_if
// valid / ready channels of the cycle timing block
// ----------------------------------------------------------------------------

// request channel: instruction and operands
interface mdct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  ea_mode;
  logic [2:0]  ea_reg;
  logic [31:0] operand_a;
  logic [15:0] operand_b;

  modport source (output valid, output func, output ea_mode, output ea_reg,
                  output operand_a, output operand_b, input ready);
  modport sink   (input valid, input func, input ea_mode, input ea_reg,
                  input operand_a, input operand_b, output ready);
endinterface

// result channel: cycle count
interface mdct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink   (input valid, input cycles, output ready);
endinterface

>>> src/mul_div_cycle_timing.sv
// ----------------------------------------------------------------------------
// mul_div_cycle_timing
// data-dependent cycle count of unsigned / signed word multiply and divide
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries func, ea_mode, ea_reg, operand_a and operand_b; a transfer
//   takes place on a clock edge where valid and ready are both high.
//   out_o returns one cycles value per request, in request order.
// Pipeline: preparation stage, three divide stages of 5 steps each, output
//   register.
// Throughput: one request per cycle while out_o.ready does not stall; the 15
//   divide steps are spread over the three divide stages so each stage holds a different request.
// Reset: rst_ni clears every stage valid bit; the pipeline comes up empty
//   and ready, with no clearing pass.
// Stall: when out_o.ready is low the result stays in the output register and
//   each stage keeps its item; empty stages still take new items, so ready on
//   in_i drops only once all five stages are full.
// ----------------------------------------------------------------------------
module mul_div_cycle_timing
  import mdct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mdct_in_if.sink    in_i,
  mdct_out_if.source out_o
);

  // preparation stage
  prep_t       prep_d;
  prep_t       prep_q;
  logic        prep_v_q;
  logic        prep_ready;
  func_e       in_func;
  logic [15:0] mul_bits;

  // divide stages
  logic      st_valid [DIV_STAGES+1];
  logic      st_ready [DIV_STAGES+1];
  div_pipe_t st_data  [DIV_STAGES+1];

  // output register
  logic       out_v_q;
  logic [7:0] cycles_q;
  logic [7:0] cycles_d;
  logic       out_ready;

  // operand preparation: magnitudes, address cost, multiply bit count
  assign in_func  = func_e'(in_i.func);
  assign mul_bits = (in_func == FUNC_MULS) ?
                    (in_i.operand_a[15:0] ^ {in_i.operand_a[14:0], 1'b0}) :
                    in_i.operand_a[15:0];

  always_comb begin
    prep_d.func = in_func;
    prep_d.cost = addr_cost(in_i.ea_mode, in_i.ea_reg);
    prep_d.zero = (in_i.operand_b == 16'd0);
    prep_d.nneg = (in_func == FUNC_DIVS) && in_i.operand_a[31];
    prep_d.dneg = (in_func == FUNC_DIVS) && in_i.operand_b[15];
    prep_d.dvd  = prep_d.nneg ? (32'd0 - in_i.operand_a) : in_i.operand_a;
    prep_d.div  = prep_d.dneg ? 16'(17'h10000 - {1'b0, in_i.operand_b}) : in_i.operand_b;
    prep_d.acc  = (in_func == FUNC_MULU || in_func == FUNC_MULS) ? pop16(mul_bits) : 5'd0;
  end

  assign prep_ready = !prep_v_q || st_ready[0];
  assign in_i.ready = prep_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (prep_ready) begin
      prep_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && prep_ready) begin
      prep_q <= prep_d;
    end
  end

  // quotient overflow checks feeding the first divide stage
  always_comb begin : ovf_check
    logic [16:0] hi;
    logic [16:0] diff;
    logic        ge;
    logic        at_min;
    logic        ovf;
    hi     = prep_q.dvd[31:15];
    ge     = hi >= {1'b0, prep_q.div};
    diff   = hi - {1'b0, prep_q.div};
    at_min = {diff[16:0], prep_q.dvd[14:0]} < {16'd0, prep_q.div};
    case (prep_q.func)
      FUNC_DIVU: ovf = prep_q.dvd[31:16] >= prep_q.div;
      FUNC_DIVS: ovf = (prep_q.nneg ^ prep_q.dneg) ? (ge && !at_min) : ge;
      default:   ovf = 1'b0;
    endcase
    st_data[0].func = prep_q.func;
    st_data[0].cost = prep_q.cost;
    st_data[0].zero = prep_q.zero;
    st_data[0].nneg = prep_q.nneg;
    st_data[0].dneg = prep_q.dneg;
    st_data[0].ovf  = ovf;
    st_data[0].div  = prep_q.div;
    st_data[0].rem  = prep_q.dvd[31:16];
    st_data[0].lo   = prep_q.dvd[15:0];
    st_data[0].acc  = prep_q.acc;
  end

  assign st_valid[0] = prep_v_q;

  // divide step stages
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    mdct_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[s]),
      .ready_o (st_ready[s]),
      .data_i  (st_data[s]),
      .valid_o (st_valid[s+1]),
      .ready_i (st_ready[s+1]),
      .data_o  (st_data[s+1])
    );
  end

  // final count from the accumulated step counts
  always_comb begin : final_count
    div_pipe_t  r;
    logic [6:0] half;
    r    = st_data[DIV_STAGES];
    half = 7'd0;
    case (r.func)
      FUNC_MULU, FUNC_MULS: begin
        cycles_d = MUL_BASE + {2'b00, r.acc, 1'b0} + {4'd0, r.cost};
      end
      FUNC_DIVU: begin
        half = DIVU_HALF + {2'b00, r.acc};
        if (r.zero) begin
          cycles_d = 8'd0;
        end else if (r.ovf) begin
          cycles_d = DIVU_OVF_BASE + {4'd0, r.cost};
        end else begin
          cycles_d = {half, 1'b0} + {4'd0, r.cost};
        end
      end
      default: begin
        half = DIVS_HALF + {6'd0, r.nneg} + {2'b00, r.acc}
             + (r.dneg ? 7'd0 : (r.nneg ? 7'd1 : 7'h7F));
        if (r.zero) begin
          cycles_d = 8'd0;
        end else if (r.ovf) begin
          cycles_d = DIVS_OVF_BASE + {6'd0, r.nneg, 1'b0} + {4'd0, r.cost};
        end else begin
          cycles_d = {half, 1'b0} + {4'd0, r.cost};
        end
      end
    endcase
  end

  // output register
  assign out_ready            = !out_v_q || out_o.ready;
  assign st_ready[DIV_STAGES] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= st_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid[DIV_STAGES] && out_ready) begin
      cycles_q <= cycles_d;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.cycles = cycles_q;

endmodule

>>> src/mdct_div_stage.sv
// ----------------------------------------------------------------------------
// mdct_div_stage
// one pipeline stage of restoring divide steps with step counting
// ----------------------------------------------------------------------------
`include "mul_div_cycle_timing_defines.svh"

module mdct_div_stage
  import mdct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  div_pipe_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output div_pipe_t data_o
);

  logic      valid_q;
  div_pipe_t data_q;
  div_pipe_t data_d;

  // restoring steps: shift in one dividend bit, subtract when it fits
  always_comb begin : div_steps
    logic [15:0] rem;
    logic [15:0] lo;
    logic [4:0]  acc;
    logic [17:0] diff;
    logic        nb;
    logic        top;
    logic        sub;
    rem = data_i.rem;
    lo  = data_i.lo;
    acc = data_i.acc;
    for (int k = 0; k < STAGE_STEPS; k++) begin
      nb   = lo[15];
      top  = rem[15];
      diff = {1'b0, rem, nb} - {2'b00, data_i.div};
      sub  = !diff[17];
      rem  = sub ? diff[15:0] : {rem[14:0], nb};
      lo   = {lo[14:0], 1'b0};
      if (data_i.func == FUNC_DIVU) begin
        acc = acc + (top ? 5'd0 : (sub ? 5'd1 : 5'd2));
      end else if (data_i.func == FUNC_DIVS) begin
        acc = acc + (sub ? 5'd0 : 5'd1);
      end
    end
    data_d     = data_i;
    data_d.rem = rem;
    data_d.lo  = lo;
    data_d.acc = acc;
  end

  // stage moves when empty or when the next stage takes its item
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // checks
  `MDCT_ASSERT(a_transfer_lands, valid_i && ready_o |=> valid_o, "accepted item not held")
  `MDCT_ASSERT(a_mul_acc_kept, valid_i && ready_o && (data_i.func == FUNC_MULU || data_i.func == FUNC_MULS) |=> data_o.acc == $past(data_i.acc), "multiply count altered")
  `MDCT_ASSERT(a_rem_below_div, valid_i && ready_o && (data_i.func == FUNC_DIVU || data_i.func == FUNC_DIVS) && !data_i.zero && !data_i.ovf && (data_i.rem < data_i.div) |=> data_o.rem < data_o.div, "remainder escaped divisor")
  `MDCT_ASSERT_RST(a_empty_in_reset, !rst_ni |=> !valid_o, "stage valid during reset")

endmodule

>>> dv/mdct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdct_checker
// watches both channels of the cycle timing block, predicts the cycle count
// of every request transfer and compares it with the returned results in order
// ----------------------------------------------------------------------------
module mdct_checker
  import mdct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mdct_in_if   in_mon,
  mdct_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // word-size address cost, by mode and by register field for mode 7
  localparam int unsigned MODE_COST [0:6] = '{0, 0, 4, 4, 6, 8, 10};
  localparam int unsigned ABS_COST  [0:7] = '{8, 12, 8, 10, 4, 8, 8, 8};

  localparam int unsigned MUL_CYCLES      = 38;
  localparam int unsigned DIVU_HALF_BASE  = 38;
  localparam int unsigned DIVU_OVF_CYCLES = 10;
  localparam int unsigned DIVS_HALF_BASE  = 6;
  localparam int unsigned DIVS_STEP_BASE  = 55;
  localparam int unsigned DIV_STEPS       = 15;

  typedef struct packed {
    func_e       func;
    logic [31:0] dvd;
    logic [15:0] dvs;
    logic [7:0]  cycles;
  } cycle_expect_t;

  cycle_expect_t cycle_count_q [$];
  int fail_cnt = 0;
  int pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  // set bits of a halfword
  function automatic int unsigned ones16(logic [15:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      n += v[i];
    end
    return n;
  endfunction

  // cycle count of one instruction
  function automatic logic [7:0] timing_cycles(func_e f, logic [2:0] mode, logic [2:0] ea_reg,
                                               logic [31:0] dvd, logic [15:0] dvs);
    int unsigned ea_cost;
    int unsigned cyc;
    int unsigned mc;
    int unsigned anum;
    int unsigned aden;
    int unsigned aq;
    logic [31:0] num;
    logic [31:0] hden;
    logic [15:0] src;
    logic [15:0] neg_dvs;
    logic        top;
    logic        nneg;
    logic        dneg;
    logic        ovf;
    ea_cost = (mode < 3'd7) ? MODE_COST[mode] : ABS_COST[ea_reg];
    src     = dvd[15:0];
    cyc     = 0;
    case (f)
      FUNC_MULU: cyc = MUL_CYCLES + 2 * ones16(src) + ea_cost;
      // transitions of the source with a zero below bit 0
      FUNC_MULS: cyc = MUL_CYCLES + 2 * ones16(src ^ {src[14:0], 1'b0}) + ea_cost;
      FUNC_DIVU: begin
        if (dvs == 16'd0) begin
          cyc = 0;
        end else if (dvd[31:16] >= dvs) begin
          cyc = DIVU_OVF_CYCLES + ea_cost;
        end else begin
          // replay the restoring divide step by step
          num  = dvd;
          hden = {dvs, 16'h0000};
          mc   = DIVU_HALF_BASE;
          for (int i = 0; i < DIV_STEPS; i++) begin
            top = num[31];
            num = num << 1;
            if (top) begin
              num = num - hden;
            end else begin
              mc += 2;
              if (num >= hden) begin
                num = num - hden;
                mc--;
              end
            end
          end
          cyc = mc * 2 + ea_cost;
        end
      end
      default: begin
        if (dvs == 16'd0) begin
          cyc = 0;
        end else begin
          nneg    = dvd[31];
          dneg    = dvs[15];
          neg_dvs = -dvs;
          anum    = nneg ? 32'(-dvd) : dvd;
          aden    = dneg ? {16'h0000, neg_dvs} : {16'h0000, dvs};
          mc      = nneg ? DIVS_HALF_BASE + 1 : DIVS_HALF_BASE;
          aq      = anum / aden;
          // opposite signs allow one more quotient magnitude
          ovf     = (nneg != dneg) ? (aq > 32768) : (aq > 32767);
          if (ovf) begin
            cyc = (mc + 2) * 2 + ea_cost;
          end else begin
            mc += DIVS_STEP_BASE;
            if (!dneg) begin
              mc = nneg ? mc + 1 : mc - 1;
            end
            for (int i = 0; i < DIV_STEPS; i++) begin
              if ((aq & 32'h8000) == 0) begin
                mc++;
              end
              aq = aq << 1;
            end
            cyc = mc * 2 + ea_cost;
          end
        end
      end
    endcase
    return 8'(cyc);
  endfunction

  // result side first, then queue the prediction of a new request transfer
  always @(posedge clk_i) begin
    cycle_expect_t head;
    cycle_expect_t pred;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (cycle_count_q.size() == 0) begin
          $display("%0t: unexpected result transfer, cycles %0d, nothing expected",
                   $time, out_mon.cycles);
          fail_cnt++;
        end else begin
          head = cycle_count_q.pop_front();
          if (out_mon.cycles !== head.cycles) begin
            $display("%0t: cycles mismatch for %s a=%h b=%h: expected %0d, actual %0d",
                     $time, head.func.name(), head.dvd, head.dvs, head.cycles,
                     out_mon.cycles);
            fail_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pred.func   = func_e'(in_mon.func);
        pred.dvd    = in_mon.operand_a;
        pred.dvs    = in_mon.operand_b;
        pred.cycles = timing_cycles(func_e'(in_mon.func), in_mon.ea_mode, in_mon.ea_reg,
                                    in_mon.operand_a, in_mon.operand_b);
        cycle_count_q.push_back(pred);
      end
      pending_cnt = cycle_count_q.size();
    end
  end

endmodule

>>> dv/tb_mul_div_cycle_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mul_div_cycle_timing
// drives directed and random multiply / divide timing requests in bursts
// against a stalling result side; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_mul_div_cycle_timing;
  import mdct_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_OPS   = 1200;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_DIRECTED   = 23;

  // receiver stall patterns
  localparam int unsigned RX_FREE  = 0;
  localparam int unsigned RX_SHORT = 1;
  localparam int unsigned RX_LONG  = 2;

  typedef struct packed {
    func_e       func;
    logic [2:0]  ea_mode;
    logic [2:0]  ea_reg;
    logic [31:0] operand_a;
    logic [15:0] operand_b;
  } timing_query_t;

  // directed requests: extremes, zero divisors, overflow and quotient bounds
  func_e dir_func [N_DIRECTED] = '{
    FUNC_MULU, FUNC_MULU, FUNC_MULU, FUNC_MULS, FUNC_MULS, FUNC_MULS,
    FUNC_DIVU, FUNC_DIVS, FUNC_DIVU, FUNC_DIVU, FUNC_DIVU, FUNC_DIVU,
    FUNC_DIVS, FUNC_DIVS, FUNC_DIVS, FUNC_DIVS, FUNC_DIVS, FUNC_DIVS,
    FUNC_DIVS, FUNC_DIVS, FUNC_DIVS, FUNC_DIVS, FUNC_DIVU
  };
  logic [31:0] dir_a [N_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8001, 32'h0000_5555, 32'h0001_AAAA,
    32'hFFFF_8000, 32'h1234_5678, 32'h8000_0000, 32'h0001_0000, 32'hFFFE_FFFF,
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
    32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000, 32'h3FFF_FFFF,
    32'h0000_0000, 32'hFFFF_FFF9, 32'hFFFF_FFFF
  };
  logic [15:0] dir_b [N_DIRECTED] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h1234,
    16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
    16'h0001, 16'h8000, 16'hFFFF, 16'h0001, 16'h0001,
    16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000,
    16'h7FFF, 16'h0002, 16'hFFFF
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int          fail_count;
  int          pending;
  int unsigned cycle_cnt = 0;
  int unsigned rx_mode = RX_FREE;

  mdct_in_if  in_if ();
  mdct_out_if out_if ();

  mul_div_cycle_timing dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mdct_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: ready runs and stalls, lengths set by the current pattern
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    run_left     = 0;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left != 0) begin
        out_if.ready <= 1'b1;
        run_left--;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        case (rx_mode)
          RX_FREE: begin
            run_left   = 64;
            stall_left = 0;
          end
          RX_SHORT: begin
            run_left   = $urandom_range(0, 8);
            stall_left = $urandom_range(1, 3);
          end
          default: begin
            run_left   = $urandom_range(0, 4);
            stall_left = $urandom_range(4, 24);
          end
        endcase
      end
    end
  end

  // one request transfer, valid held until accepted
  task automatic send_query(input timing_query_t q);
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.func      <= q.func;
    in_if.ea_mode   <= q.ea_mode;
    in_if.ea_reg    <= q.ea_reg;
    in_if.operand_a <= q.operand_a;
    in_if.operand_b <= q.operand_b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // sender gap with scrambled payload
  task automatic idle_sender(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      in_if.valid     <= 1'b0;
      in_if.func      <= 2'($urandom);
      in_if.operand_a <= $urandom;
      in_if.operand_b <= 16'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // wait for every outstanding result
  task automatic drain_results();
    while (pending != 0) @(negedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    timing_query_t q;
    int unsigned   sent;
    int unsigned   burst;
    int unsigned   shape;
    int            dmag;
    int            quot;
    int            rem;
    longint        prod;
    in_if.valid     = 1'b0;
    in_if.func      = FUNC_MULU;
    in_if.ea_mode   = 3'd0;
    in_if.ea_reg    = 3'd0;
    in_if.operand_a = 32'd0;
    in_if.operand_b = 16'd0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, walking through every address form
    rx_mode = RX_SHORT;
    for (int i = 0; i < N_DIRECTED; i++) begin
      q.func      = dir_func[i];
      q.ea_mode   = ((i % 15) < 7) ? 3'(i % 15) : 3'd7;
      q.ea_reg    = ((i % 15) < 7) ? 3'(i % 15) : 3'((i % 15) - 7);
      q.operand_a = dir_a[i];
      q.operand_b = dir_b[i];
      send_query(q);
    end
    idle_sender(1);
    drain_results();

    // random part in bursts
    sent = 0;
    while (sent < RANDOM_OPS) begin
      burst = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RANDOM_OPS; k++) begin
        q.func      = func_e'($urandom_range(0, 3));
        q.ea_mode   = 3'($urandom_range(0, 7));
        q.ea_reg    = 3'($urandom_range(0, 7));
        q.operand_a = $urandom;
        q.operand_b = 16'($urandom);
        shape       = $urandom_range(0, 9);
        case (q.func)
          FUNC_MULU, FUNC_MULS: begin
            if (shape == 0) q.operand_a[15:0] = 16'hFFFF;
            else if (shape == 1) q.operand_a[15:0] = 16'h0000;
          end
          FUNC_DIVU: begin
            // mostly quotients that fit, small and full-range divisors
            if (shape == 0) begin
              q.operand_b = 16'h0000;
            end else if (shape >= 3) begin
              q.operand_b = (shape < 6) ? 16'($urandom_range(1, 255))
                                        : 16'($urandom_range(1, 65535));
              q.operand_a[31:16] = 16'($urandom_range(0, q.operand_b - 1));
            end
          end
          default: begin
            // dividend built from a quotient in range plus a remainder
            if (shape == 0) begin
              q.operand_b = 16'h0000;
            end else if (shape >= 3) begin
              dmag = (shape < 6) ? int'($urandom_range(1, 255))
                                 : int'($urandom_range(1, 32768));
              quot = int'($urandom_range(0, 65535)) - 32768;
              rem  = int'($urandom_range(0, dmag - 1));
              if ($urandom_range(0, 1) == 1) dmag = -dmag;
              prod = longint'(quot) * longint'(dmag);
              if (prod < 0 || (prod == 0 && $urandom_range(0, 1) == 1)) prod = prod - rem;
              else prod = prod + rem;
              q.operand_a = 32'(prod);
              q.operand_b = 16'(dmag);
            end
          end
        endcase
        send_query(q);
        sent++;
        // hold off once until the pipeline has emptied
        if (sent == RANDOM_OPS / 2) begin
          idle_sender(1);
          drain_results();
        end
      end
      if ($urandom_range(0, 5) == 0) rx_mode = $urandom_range(RX_FREE, RX_LONG);
      idle_sender($urandom_range(1, 6));
    end

    // wait out the pipeline
    idle_sender(1);
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
